FILE: rtl/lru_key_value_cache_unit_assert.svh
// ----------------------------------------------------------------------------
// lru key/value cache assertion macros
// shared property wrappers for the cache rtl
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define LKVC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("lkvc assertion failed");

// implication whose consequent is checked in the next cycle
`define LKVC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lkvc next-cycle assertion failed");

`endif

FILE: rtl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// sizes, codes and types of the lru key/value cache
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int AGE_W   = IDX_W;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } opcode_t;

endpackage

`default_nettype wire

FILE: rtl/lru_key_value_cache_unit.sv
// ----------------------------------------------------------------------------
// lru key/value cache unit
// fully associative key/value store with least-recently-used replacement
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_*      | in        | tdata: key, write_value   tuser: opcode
//  m_*      | out       | tdata: read_value         tuser: found
//  cfg_*    | in        | capacity write, no read-back
//
//  one word per cycle sustained while results are taken; a get's result passes
//  through the input register, then the result register; a put gives none
//  all entries compare and age in parallel between the input and result registers
//  reset clears the valid bits, ages and occupancy and sets capacity to 16
//  a stalled result holds gets in the input register; puts still proceed
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_unit (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [lkvc_pkg::CAP_W-1:0]              cfg_wdata,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // key, write_value
  input  logic [lkvc_pkg::KEY_W+lkvc_pkg::VAL_W-1:0] s_tdata,
  // opcode
  input  logic                                    s_tuser,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // read_value
  output logic [lkvc_pkg::VAL_W-1:0]              m_tdata,
  // found
  output logic                                    m_tuser
);

  import lkvc_pkg::*;

  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CAP_W-1:0] capacity;

  logic             in_valid;
  opcode_t          in_op;
  logic [KEY_W-1:0] in_key;
  logic [VAL_W-1:0] in_val;

  logic [KEY_W-1:0] entry_keys   [ENTRIES];
  logic [VAL_W-1:0] entry_values [ENTRIES];
  logic [AGE_W-1:0] entry_age    [ENTRIES];
  logic [ENTRIES-1:0] entry_valid;
  logic [CNT_W-1:0]   occupancy;

  logic               out_free;
  logic               advance;
  logic               is_put;
  logic [ENTRIES-1:0] hit_vec;
  logic               hit;
  logic [AGE_W-1:0]   hit_age;
  logic [VAL_W-1:0]   hit_val;
  logic [CMP_W-1:0]   cap_eff;
  logic               full;
  logic [AGE_W-1:0]   oldest_age;
  logic [ENTRIES-1:0] oldest_vec;
  logic [ENTRIES-1:0] free_vec;
  logic [ENTRIES-1:0] fill_vec;
  logic               evict;
  logic               fill;
  logic               touch_any;
  logic [ENTRIES-1:0] touch_vec;
  logic [AGE_W-1:0]   touch_age;
  logic [ENTRIES-1:0] key_wr_vec;
  logic [ENTRIES-1:0] val_wr_vec;

  assign out_free = !m_tvalid || m_tready;
  assign is_put   = (in_op == OP_PUT);
  assign advance  = in_valid && (is_put || out_free);
  assign s_tready = !in_valid || advance;

  // parallel key compare and hit readout
  always_comb begin
    hit_age = '0;
    hit_val = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = entry_valid[i] && (entry_keys[i] == in_key);
      hit_age    = hit_age | (entry_age[i] & {AGE_W{hit_vec[i]}});
      hit_val    = hit_val | (entry_values[i] & {VAL_W{hit_vec[i]}});
    end
    hit = |hit_vec;
  end

  always_comb begin
    priority if (capacity == '0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end else begin
      cap_eff = CMP_W'(capacity);
    end
  end

  assign full       = CMP_W'(occupancy) >= cap_eff;
  assign oldest_age = AGE_W'(occupancy - CNT_W'(1));

  // least recent entry holds age occupancy-1
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      oldest_vec[i] = entry_valid[i] && (entry_age[i] == oldest_age);
    end
  end

  assign free_vec  = ~entry_valid;
  assign fill_vec  = free_vec & (~free_vec + ENTRIES'(1));
  assign evict     = is_put && !hit && full;
  assign fill      = is_put && !hit && !full;
  assign touch_any = hit || evict;
  assign touch_vec = hit ? hit_vec : (evict ? oldest_vec : '0);
  assign touch_age = hit ? hit_age : oldest_age;
  assign key_wr_vec = evict ? oldest_vec : (fill ? fill_vec : '0);
  assign val_wr_vec = (is_put && hit) ? hit_vec : key_wr_vec;

  // control state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= CAP_RESET;
      in_valid    <= 1'b0;
      entry_valid <= '0;
      occupancy   <= '0;
      m_tvalid    <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        entry_age[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (touch_vec[i] || (fill && fill_vec[i])) begin
            entry_age[i] <= '0;
          end else if (entry_valid[i] &&
                       (fill || (touch_any && entry_age[i] < touch_age))) begin
            entry_age[i] <= entry_age[i] + AGE_W'(1);
          end
        end
        if (fill) begin
          entry_valid <= entry_valid | fill_vec;
          occupancy   <= occupancy + CNT_W'(1);
        end
      end
      if (advance && !is_put) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op  <= opcode_t'(s_tuser);
      in_key <= s_tdata[KEY_W-1:0];
      in_val <= s_tdata[KEY_W+VAL_W-1:KEY_W];
    end
    if (advance && !is_put) begin
      m_tuser <= hit;
      m_tdata <= hit_val;
    end
    if (advance) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (key_wr_vec[i]) begin
          entry_keys[i] <= in_key;
        end
        if (val_wr_vec[i]) begin
          entry_values[i] <= in_val;
        end
      end
    end
  end

`include "lru_key_value_cache_unit_assert.svh"

  `LKVC_ASSERT(a_occ_bound, CNT_W'(ENTRIES) >= occupancy)
  `LKVC_ASSERT(a_occ_matches_valid, $countones(entry_valid) == int'(occupancy))
  `LKVC_ASSERT(a_keys_unique, in_valid |-> $onehot0(hit_vec))
  `LKVC_ASSERT_NEXT(a_put_no_result, advance && is_put && out_free, !m_tvalid)
  `LKVC_ASSERT_NEXT(a_fill_grows, advance && fill, occupancy == $past(occupancy) + CNT_W'(1))

endmodule

`default_nettype wire

FILE: sim/tb_lru_key_value_cache_unit.sv
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_unit
// self-checking bench for the lru key/value cache unit: a short table of
// gets and puts opens the run, then random traffic over several capacity
// settings, replies held to table values or a mirror of the cache contents
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lru_key_value_cache_unit;
  import lkvc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 8;
  localparam int POOL_SIZE = 24;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] value;
  } reply_t;

  typedef struct {
    opcode_t          op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] wval;
    bit               fixed;
    reply_t           reply;
  } dir_row_t;

  typedef struct {
    logic [CAP_W-1:0] cap;
    int               mode;
    int               count;
    int               hold;
    bit               pause;
  } phase_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CAP_W-1:0]       cfg_wdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [KEY_W+VAL_W-1:0] s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [VAL_W-1:0]       m_tdata;
  logic                   m_tuser;

  // cache mirror
  logic [KEY_W-1:0] mirror_keys [ENTRIES];
  logic [VAL_W-1:0] mirror_vals [ENTRIES];
  bit               mirror_valid [ENTRIES];
  int               mirror_age [ENTRIES];
  int               mirror_occ = 0;
  logic [CAP_W-1:0] mirror_cap = CAP_RESET;

  reply_t lookup_replies [$];
  dir_row_t dir_rows [$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  int errors = 0;
  int cycles = 0;
  int idle_mode = 0;
  int hold_request = 0;
  int hold_left = 0;
  int n_gets = 0;
  int n_puts = 0;
  int n_hits = 0;
  int n_cfg = 0;

  lru_key_value_cache_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // key, write_value
    .s_tuser  (s_tuser),   // opcode
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // read_value
    .m_tuser  (m_tuser)    // found
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout, %0d replies outstanding", $time, lookup_replies.size());
      $display("lru_key_value_cache_unit test failed");
      $finish;
    end
  end

  // make an entry most recent
  function automatic void touch_entry(int slot);
    int lim;
    lim = mirror_age[slot];
    for (int i = 0; i < ENTRIES; i++)
      if (mirror_valid[i] && mirror_age[i] < lim) mirror_age[i]++;
    mirror_age[slot] = 0;
  endfunction

  // applies one word to the mirror; returns 1 when a reply follows
  function automatic bit cache_access(opcode_t op, logic [KEY_W-1:0] key,
                                      logic [VAL_W-1:0] wval, output reply_t rep);
    int slot;
    int cap;
    int victim;
    slot = -1;
    victim = -1;
    cap = mirror_cap;
    rep = '0;
    if (cap == 0) cap = 1;
    if (cap > ENTRIES) cap = ENTRIES;
    for (int i = ENTRIES - 1; i >= 0; i--)
      if (mirror_valid[i] && mirror_keys[i] == key) slot = i;
    if (op == OP_GET) begin
      if (slot >= 0) begin
        touch_entry(slot);
        rep.found = 1'b1;
        rep.value = mirror_vals[slot];
      end
      return 1'b1;
    end
    if (slot >= 0) begin
      mirror_vals[slot] = wval;
      touch_entry(slot);
    end else if (mirror_occ >= cap) begin
      for (int i = 0; i < ENTRIES; i++)
        if (mirror_valid[i] && (victim < 0 || mirror_age[i] > mirror_age[victim]))
          victim = i;
      touch_entry(victim);
      mirror_keys[victim] = key;
      mirror_vals[victim] = wval;
    end else begin
      for (int i = 0; i < ENTRIES; i++)
        if (!mirror_valid[i] && victim < 0) victim = i;
      for (int i = 0; i < ENTRIES; i++)
        if (mirror_valid[i]) mirror_age[i]++;
      mirror_valid[victim] = 1'b1;
      mirror_keys[victim] = key;
      mirror_vals[victim] = wval;
      mirror_age[victim] = 0;
      mirror_occ++;
    end
    return 1'b0;
  endfunction

  function automatic int sender_idle_pct();
    return (idle_mode == 1) ? 79 : (idle_mode == 3) ? 35 : 0;
  endfunction

  task automatic send_word(opcode_t op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] wval,
                           bit fixed, reply_t fixed_reply);
    reply_t rep;
    int pct;
    pct = sender_idle_pct();
    if (pct > 0 && $urandom_range(99) < pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {wval, key};
    do @(posedge clk); while (!s_tready);
    if (cache_access(op, key, wval, rep)) begin
      lookup_replies.push_back(fixed ? fixed_reply : rep);
      n_gets++;
      if (rep.found) n_hits++;
    end else begin
      n_puts++;
    end
  endtask

  task automatic wait_replies();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (lookup_replies.size() != 0);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    wait_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    mirror_cap = cap;
    n_cfg++;
  endtask

  task automatic add_row(opcode_t op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] wval,
                         bit fixed, logic found, logic [VAL_W-1:0] value);
    dir_row_t r;
    r.op = op;
    r.key = key;
    r.wval = wval;
    r.fixed = fixed;
    r.reply.found = found;
    r.reply.value = value;
    dir_rows.push_back(r);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(99);
    if (roll < 85) return key_pool[$urandom_range(POOL_SIZE - 1)];
    if (roll < 95) return $urandom;
    return (roll < 97) ? '0 : '1;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 4) return '0;
    if (roll < 8) return '1;
    return $urandom;
  endfunction

  // reply stall, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (idle_mode == 2) begin
      m_tready <= ($urandom_range(99) >= 79);
    end else if (idle_mode == 3) begin
      m_tready <= ($urandom_range(99) >= 35);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (lookup_replies.size() == 0) begin
        $display("%0t unexpected reply found=%0b value=%h", $time, m_tuser, m_tdata);
        errors++;
      end else begin
        want = lookup_replies.pop_front();
        if (m_tuser !== want.found) begin
          $display("%0t found mismatch: expected %0b actual %0b", $time, want.found, m_tuser);
          errors++;
        end
        if (m_tdata !== want.value) begin
          $display("%0t read_value mismatch: expected %h actual %h", $time, want.value,
                   m_tdata);
          errors++;
        end
      end
    end
  end

  initial begin
    phase_t phases [$];
    phase_t ph;
    dir_row_t r;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty cache, reset capacity
    add_row(OP_GET, 32'h0000_0000, 32'h0, 1, 1'b0, 32'h0);
    add_row(OP_GET, 32'hFFFF_FFFF, 32'h0, 1, 1'b0, 32'h0);
    add_row(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF, 0, 1'b0, 32'h0);
    add_row(OP_GET, 32'h0000_0000, 32'h0, 1, 1'b1, 32'hFFFF_FFFF);
    add_row(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000, 0, 1'b0, 32'h0);
    add_row(OP_GET, 32'hFFFF_FFFF, 32'h0, 1, 1'b1, 32'h0000_0000);
    // overwrite of a present key
    add_row(OP_PUT, 32'h0000_0000, 32'h5A5A_5A5A, 0, 1'b0, 32'h0);
    add_row(OP_GET, 32'h0000_0000, 32'h0, 1, 1'b1, 32'h5A5A_5A5A);
    add_row(OP_GET, 32'h0000_0001, 32'h0, 1, 1'b0, 32'h0);
    add_row(OP_PUT, 32'h8000_0000, 32'h0000_0001, 0, 1'b0, 32'h0);
    add_row(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1'b0, 32'h0);
    add_row(OP_GET, 32'h7FFF_FFFF, 32'h0, 1, 1'b1, 32'h8000_0000);
    add_row(OP_GET, 32'h8000_0000, 32'h0, 1, 1'b1, 32'h0000_0001);
    add_row(OP_PUT, 32'h1234_5678, 32'hA5A5_A5A5, 0, 1'b0, 32'h0);
    add_row(OP_GET, 32'hFFFF_FFFE, 32'h0, 1, 1'b0, 32'h0);
    add_row(OP_GET, 32'h1234_5678, 32'h0, 0, 1'b0, 32'h0);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      send_word(r.op, r.key, r.wval, r.fixed, r.reply);
    end

    // zero capacity acts as one and sits below the current fill
    phases.push_back('{5'd0, 0, 70, 0, 0});
    phases.push_back('{5'd1, 1, 70, 0, 0});
    phases.push_back('{5'd3, 2, 80, 0, 0});
    phases.push_back('{5'd8, 3, 80, 0, 0});
    phases.push_back('{5'd12, 0, 90, 300, 1});
    phases.push_back('{5'd31, 1, 80, 0, 0});
    phases.push_back('{5'd17, 2, 80, 0, 0});
    phases.push_back('{5'd16, 3, 90, 0, 0});

    foreach (key_pool[i]) key_pool[i] = $urandom;
    foreach (phases[p]) begin
      ph = phases[p];
      write_capacity(ph.cap);
      idle_mode = ph.mode;
      for (int i = 0; i < POOL_SIZE; i++)
        if ($urandom_range(1)) key_pool[i] = $urandom;
      if (ph.hold > 0) hold_request = ph.hold;
      for (int i = 0; i < ph.count; i++) begin
        if (ph.pause && i == ph.count / 2) wait_replies();
        send_word(opcode_t'($urandom_range(1)), pick_key(), pick_value(), 0, '0);
      end
    end

    idle_mode = 0;
    wait_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d words: %0d puts, %0d gets (%0d hits)", n_gets + n_puts,
             n_puts, n_gets, n_hits);
    $display("%0d capacity writes, zero and saturated values included, %0d errors", n_cfg,
             errors);
    if (errors == 0) begin
      $display("lru_key_value_cache_unit test passed");
    end else begin
      $display("lru_key_value_cache_unit test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
